### design/dscl_pkg.sv
// Shared types and constants for the debounced sequence code lock.
// Used by dscl_core and debounced_sequence_code_lock_top; no dependencies.
package dscl_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_CODE_SYMBOLS   = 2'd0;
  localparam logic [1:0] REG_CODE_LENGTH    = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd3;

  // Configuration reset values: code 2,2,2,3,3,1,0,0 packed two bits a position
  localparam logic [15:0] RST_CODE_SYMBOLS   = 16'd2026;
  localparam logic [3:0]  RST_CODE_LENGTH    = 4'd8;
  localparam logic [15:0] RST_DEBOUNCE_TICKS = 16'd40;
  localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd5000;

  // Positions covered by the code register
  localparam int CODE_POSITIONS = 8;

  // Verdict codes
  localparam logic [1:0] VERDICT_NONE  = 2'd0;
  localparam logic [1:0] VERDICT_OPEN  = 2'd1;
  localparam logic [1:0] VERDICT_WRONG = 2'd2;

  // Override text matcher codes and characters
  localparam logic [2:0] TXT_EMPTY = 3'd0;
  localparam logic [2:0] TXT_B     = 3'd1;
  localparam logic [2:0] TXT_BL    = 3'd2;
  localparam logic [2:0] TXT_BLE   = 3'd3;
  localparam logic [2:0] TXT_OTHER = 3'd4;
  localparam logic [7:0] CHAR_NL = 8'd10;
  localparam logic [7:0] CHAR_B  = 8'h42;
  localparam logic [7:0] CHAR_L  = 8'h4C;
  localparam logic [7:0] CHAR_E  = 8'h45;

  typedef struct packed {
    logic [15:0] code_symbols;
    logic [3:0]  code_length;
    logic [15:0] debounce_ticks;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       key_pressed;
    logic [1:0] key_number;
    logic [1:0] verdict;
    logic       timed_out;
    logic       override_open;
    logic [3:0] entries_held;
  } res_t;

  // Expected symbol at one position; positions past the register expect zero
  function automatic logic [1:0] expected_symbol(input logic [15:0] symbols, input int pos);
    logic [1:0] sym;
    sym = 2'd0;
    for (int p = 0; p < CODE_POSITIONS; p++) begin
      if (p == pos) sym = symbols[2*p +: 2];
    end
    return sym;
  endfunction

  // Advance the override text matcher by one received byte
  function automatic logic [2:0] next_text_state(input logic [2:0] st, input logic [7:0] ch);
    logic [2:0] nx;
    nx = TXT_OTHER;
    if (ch == CHAR_NL) nx = TXT_EMPTY;
    else if (st == TXT_EMPTY && ch == CHAR_B) nx = TXT_B;
    else if (st == TXT_B && ch == CHAR_L) nx = TXT_BL;
    else if (st == TXT_BL && ch == CHAR_E) nx = TXT_BLE;
    return nx;
  endfunction

endpackage

### design/dscl_core.sv
// Lock state and per-tick logic: text match, code check, debounce, timeout.
// Depends on dscl_pkg; instantiated by debounced_sequence_code_lock_top.
module dscl_core
  import dscl_pkg::*;
#(
  parameter int MAX_CODE_LENGTH = 8,
  parameter int BUTTON_COUNT    = 4,
  parameter int COUNT_WIDTH     = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  cfg_t                    cfg,
  input  logic [BUTTON_COUNT-1:0] button_levels,
  input  logic                    rx_valid,
  input  logic [7:0]              rx_byte,
  output res_t                    res
);

  localparam int LEN_W = $clog2(MAX_CODE_LENGTH + 1);
  localparam int IDX_W = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;
  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CODE_LENGTH);

  logic [BUTTON_COUNT-1:0] stable_r, stable_nxt;
  logic [BUTTON_COUNT-1:0] prev_raw_r;
  logic [COUNT_WIDTH-1:0]  quiet_r, quiet_nxt;
  logic [COUNT_WIDTH-1:0]  idle_r, idle_nxt;
  logic [LEN_W-1:0]        entry_cnt_r, entry_cnt_nxt;
  logic [2:0]              txt_r, txt_nxt;
  logic [1:0]              entered_r [MAX_CODE_LENGTH];
  logic [1:0]              entered_nxt [MAX_CODE_LENGTH];

  logic [LEN_W-1:0]        len_eff;
  logic                    check, code_ok, chg_seen, pressed, timed_out;
  logic [1:0]              key;
  logic [COUNT_WIDTH-1:0]  quiet_up;

  // Clamp the code length into 1..MAX_CODE_LENGTH
  always_comb begin
    if (cfg.code_length == 4'd0) begin
      len_eff = LEN_W'(1);
    end else if (int'(cfg.code_length) > MAX_CODE_LENGTH) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = LEN_W'(cfg.code_length);
    end
  end

  // Compare the finished entry against the code
  always_comb begin
    code_ok = 1'b1;
    for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
      if (i < int'(len_eff) && entered_r[i] != expected_symbol(cfg.code_symbols, i))
        code_ok = 1'b0;
    end
  end

  assign check    = (entry_cnt_r >= len_eff);
  assign quiet_up = (quiet_r == COUNT_MAX) ? quiet_r : quiet_r + 1'b1;

  // One tick: text, check, debounce and record, then timeout
  always_comb begin
    txt_nxt = rx_valid ? next_text_state(txt_r, rx_byte) : txt_r;
    entry_cnt_nxt = check ? '0 : entry_cnt_r;
    idle_nxt = (idle_r == COUNT_MAX) ? idle_r : idle_r + 1'b1;
    stable_nxt = stable_r;
    entered_nxt = entered_r;
    chg_seen = 1'b0;
    pressed = 1'b0;
    key = 2'd0;
    timed_out = 1'b0;
    for (int k = 0; k < BUTTON_COUNT; k++) begin
      // a change on this or an earlier button clears the shared quiet count
      if (button_levels[k] != prev_raw_r[k]) chg_seen = 1'b1;
      if (!chg_seen && CMP_W'(quiet_up) > CMP_W'(cfg.debounce_ticks) &&
          button_levels[k] != stable_r[k]) begin
        stable_nxt[k] = button_levels[k];
        if (!button_levels[k] && entry_cnt_nxt < len_eff) begin
          entered_nxt[entry_cnt_nxt[IDX_W-1:0]] = 2'(k);
          entry_cnt_nxt = entry_cnt_nxt + 1'b1;
          pressed = 1'b1;
          key = 2'(k);
          idle_nxt = '0;
        end
      end
    end
    quiet_nxt = chg_seen ? '0 : quiet_up;
    if (CMP_W'(idle_nxt) > CMP_W'(cfg.timeout_ticks) && entry_cnt_nxt != '0) begin
      entry_cnt_nxt = '0;
      idle_nxt = '0;
      timed_out = 1'b1;
    end
  end

  // Result of this tick
  always_comb begin
    res.key_pressed   = pressed;
    res.key_number    = key;
    res.verdict       = check ? (code_ok ? VERDICT_OPEN : VERDICT_WRONG) : VERDICT_NONE;
    res.timed_out     = timed_out;
    res.override_open = (txt_nxt == TXT_BLE);
    res.entries_held  = 4'(entry_cnt_nxt);
  end

  // Advance the state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r    <= '0;
      prev_raw_r  <= '0;
      quiet_r     <= '0;
      idle_r      <= '0;
      entry_cnt_r <= '0;
      txt_r       <= TXT_EMPTY;
    end else if (step) begin
      stable_r    <= stable_nxt;
      prev_raw_r  <= button_levels;
      quiet_r     <= quiet_nxt;
      idle_r      <= idle_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      txt_r       <= txt_nxt;
    end
  end

  // Hold entered buttons; no reset, only written entries are ever compared
  always_ff @(posedge clk) begin
    if (step) entered_r <= entered_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(entry_cnt_r) <= MAX_CODE_LENGTH)
    else $error("entry count beyond maximum code length");

  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.timed_out |=> entry_cnt_r == '0 && idle_r == '0)
    else $error("timeout did not clear entry");

  a_check_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.verdict != VERDICT_NONE && !res.key_pressed |=> entry_cnt_r == '0)
    else $error("code check did not clear entry");

  a_press_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.key_pressed && !res.timed_out |=> idle_r == '0)
    else $error("recorded press did not clear idle count");

endmodule

### design/debounced_sequence_code_lock_top.sv
// Debounced sequence code lock: one item is one tick, producing one result item.
// The result is registered in the buffer head, or in its skid entry on a stall.
// One item per cycle unless in_stall; a two-entry buffer absorbs a stall.
// Reset (rst_n low, synchronous): counters, matcher and buffer clear,
// configuration returns to its defaults. Depends on dscl_pkg and dscl_core.
module debounced_sequence_code_lock_top
  import dscl_pkg::*;
#(
  parameter int MAX_CODE_LENGTH = 8,
  parameter int BUTTON_COUNT    = 4,
  parameter int COUNT_WIDTH     = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [BUTTON_COUNT-1:0] in_button_levels,
  input  logic                    in_rx_valid,
  input  logic [7:0]              in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_key_pressed,
  output logic [1:0]              out_key_number,
  output logic [1:0]              out_verdict,
  output logic                    out_timed_out,
  output logic                    out_override_open,
  output logic [3:0]              out_entries_held
);

  cfg_t cfg_r;
  res_t res, head_r, skid_r;
  logic head_valid_r, skid_valid_r;
  logic push, pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_symbols   <= RST_CODE_SYMBOLS;
      cfg_r.code_length    <= RST_CODE_LENGTH;
      cfg_r.debounce_ticks <= RST_DEBOUNCE_TICKS;
      cfg_r.timeout_ticks  <= RST_TIMEOUT_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CODE_SYMBOLS:   cfg_r.code_symbols   <= cfg_data;
        REG_CODE_LENGTH:    cfg_r.code_length    <= cfg_data[3:0];
        REG_DEBOUNCE_TICKS: cfg_r.debounce_ticks <= cfg_data;
        REG_TIMEOUT_TICKS:  cfg_r.timeout_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign push     = in_valid && !skid_valid_r;
  assign pop      = head_valid_r && !out_stall;

  dscl_core #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH),
    .BUTTON_COUNT   (BUTTON_COUNT),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (push),
    .cfg          (cfg_r),
    .button_levels(in_button_levels),
    .rx_valid     (in_rx_valid),
    .rx_byte      (in_rx_byte),
    .res          (res)
  );

  // Output buffer control: refill head from skid first, park in skid on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!head_valid_r || pop) head_valid_r <= skid_valid_r || push;
      if (skid_valid_r) begin
        if (pop) skid_valid_r <= 1'b0;
      end else if (push && head_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (!head_valid_r || pop) head_r <= skid_valid_r ? skid_r : res;
    if (!skid_valid_r && push && head_valid_r && !pop) skid_r <= res;
  end

  assign out_valid         = head_valid_r;
  assign out_key_pressed   = head_r.key_pressed;
  assign out_key_number    = head_r.key_number;
  assign out_verdict       = head_r.verdict;
  assign out_timed_out     = head_r.timed_out;
  assign out_override_open = head_r.override_open;
  assign out_entries_held  = head_r.entries_held;

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> head_valid_r)
    else $error("skid entry held with empty head");

  a_stall_keeps_head: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid_r && out_stall |=> head_valid_r && $stable(head_r))
    else $error("stalled result item lost");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> !skid_valid_r && head_r == $past(skid_r))
    else $error("skid item not moved to head");

endmodule
